>>> hw/rtl/wwdt_pkg.sv
package wwdt_pkg;

  // item kinds
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register byte offsets
  localparam logic [9:0] OFS_MOD  = 10'h000;
  localparam logic [9:0] OFS_TC   = 10'h004;
  localparam logic [9:0] OFS_FEED = 10'h008;
  localparam logic [9:0] OFS_TV   = 10'h00C;
  localparam logic [9:0] OFS_WARN = 10'h014;
  localparam logic [9:0] OFS_WIN  = 10'h018;

  // mode register bit positions
  localparam int unsigned MB_EN   = 0;
  localparam int unsigned MB_RST  = 1;
  localparam int unsigned MB_TOF  = 2;
  localparam int unsigned MB_INT  = 3;
  localparam int unsigned MB_PROT = 4;

  // reset causes
  localparam logic [2:0] CAUSE_NONE    = 3'd0;
  localparam logic [2:0] CAUSE_TIMEOUT = 3'd1;
  localparam logic [2:0] CAUSE_BREAK   = 3'd2;
  localparam logic [2:0] CAUSE_WINDOW  = 3'd3;
  localparam logic [2:0] CAUSE_PROT    = 3'd4;

  localparam logic [31:0] TC_FLOOR    = 32'h0000_00FF;
  localparam logic [31:0] WIN_OPEN    = 32'h00FF_FFFF;
  localparam logic [7:0]  FEED_FIRST  = 8'hAA;
  localparam logic [7:0]  FEED_SECOND = 8'h55;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  addr;
    logic [31:0] wdata;
  } wwdt_item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic        reset_request;
    logic [2:0]  reset_cause;
  } wwdt_res_t;

endpackage

>>> hw/rtl/wwdt_core.sv
module wwdt_core import wwdt_pkg::*; #(
  parameter int ADDR_SPAN = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  wwdt_item_t item,
  output wwdt_res_t  res
);

  logic [4:0]  mode_r, mode_nxt;
  logic [31:0] tc_r, tc_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [9:0]  warn_r, warn_nxt;
  logic [31:0] win_r, win_nxt;
  logic        half_r, half_nxt;
  logic        fed_r, fed_nxt;
  logic        cnt_on_r, cnt_on_nxt;
  logic        armed_r, armed_nxt;

  logic [31:0] tv;
  logic [31:0] warn_ext;
  logic [31:0] cnt_dec;
  logic        in_span;
  logic        brk;
  logic [2:0]  cause;
  logic [31:0] rdata;

  assign tv       = cnt_on_r ? cnt_r : tc_r;
  assign warn_ext = {22'd0, warn_r};
  assign cnt_dec  = (cnt_r != 32'd0) ? cnt_r - 32'd1 : 32'd0;
  assign in_span  = 32'(item.addr) < 32'(ADDR_SPAN);

  always_comb begin
    mode_nxt   = mode_r;
    tc_nxt     = tc_r;
    cnt_nxt    = cnt_r;
    warn_nxt   = warn_r;
    win_nxt    = win_r;
    half_nxt   = half_r;
    fed_nxt    = fed_r;
    cnt_on_nxt = cnt_on_r;
    armed_nxt  = armed_r;
    cause      = CAUSE_NONE;
    rdata      = 32'd0;
    brk        = 1'b0;

    if (item.req_type == REQ_TICK) begin
      if (cnt_on_r) begin
        cnt_nxt = cnt_dec;
        if (armed_r && cnt_dec == warn_ext) begin
          mode_nxt[MB_INT] = 1'b1;
          armed_nxt        = 1'b0;
        end
        if (cnt_dec == 32'd0) begin
          mode_nxt[MB_TOF] = 1'b1;
          cnt_on_nxt       = 1'b0;
          if (mode_r[MB_RST]) begin
            cause = CAUSE_TIMEOUT;
          end else if (mode_r[MB_EN]) begin
            cnt_nxt    = tc_r;
            cnt_on_nxt = 1'b1;
            armed_nxt  = (warn_r != 10'd0) && (warn_ext < tc_r);
          end else begin
            armed_nxt = 1'b0;
          end
        end
      end
    end else if ((item.req_type == REQ_READ || item.req_type == REQ_WRITE) && in_span) begin
      // an open feed sequence is broken by any in-span access but a write of the second feed byte
      brk = half_r && !(item.req_type == REQ_WRITE && item.addr == OFS_FEED &&
                        item.wdata[7:0] == FEED_SECOND);
      if (brk) begin
        half_nxt = 1'b0;
        if (mode_r[MB_EN] && fed_r) begin
          mode_nxt[MB_TOF] = 1'b1;
          cause            = CAUSE_BREAK;
        end
      end

      if (item.req_type == REQ_READ) begin
        case (item.addr)
          OFS_MOD:  rdata = {27'd0, mode_nxt};
          OFS_TC:   rdata = tc_r;
          OFS_TV:   rdata = tv;
          OFS_WARN: rdata = warn_ext;
          OFS_WIN:  rdata = win_r;
          default:  rdata = 32'd0;
        endcase
      end else if (cause == CAUSE_NONE) begin
        case (item.addr)
          OFS_MOD: begin
            mode_nxt[MB_EN]   = mode_r[MB_EN] | item.wdata[MB_EN];
            mode_nxt[MB_RST]  = mode_r[MB_RST] | item.wdata[MB_RST];
            mode_nxt[MB_PROT] = mode_r[MB_PROT] | item.wdata[MB_PROT];
            if (!item.wdata[MB_TOF]) begin
              mode_nxt[MB_TOF] = 1'b0;
            end
            if (item.wdata[MB_INT]) begin
              mode_nxt[MB_INT] = 1'b0;
            end
          end
          OFS_TC: begin
            if (mode_r[MB_PROT] && (tv >= warn_ext || tv >= win_r)) begin
              cause = CAUSE_PROT;
            end else begin
              tc_nxt = (item.wdata < TC_FLOOR) ? TC_FLOOR : item.wdata;
            end
          end
          OFS_FEED: begin
            if (half_nxt && item.wdata[7:0] == FEED_SECOND) begin
              half_nxt = 1'b0;
              if (mode_r[MB_EN]) begin
                if (fed_r && win_r < WIN_OPEN && tv > win_r) begin
                  cause = CAUSE_WINDOW;
                end else begin
                  fed_nxt    = 1'b1;
                  cnt_nxt    = tc_r;
                  cnt_on_nxt = 1'b1;
                  armed_nxt  = (warn_r != 10'd0) && (warn_ext < tc_r);
                end
              end
            end else if (item.wdata[7:0] == FEED_FIRST) begin
              half_nxt = 1'b1;
            end
          end
          OFS_WARN: warn_nxt = item.wdata[9:0];
          OFS_WIN:  win_nxt  = item.wdata;
          default: ;
        endcase
      end
    end

    if (cause != CAUSE_NONE) begin
      mode_nxt   = 5'd0;
      tc_nxt     = TC_FLOOR;
      cnt_nxt    = 32'd0;
      warn_nxt   = 10'd0;
      win_nxt    = WIN_OPEN;
      half_nxt   = 1'b0;
      fed_nxt    = 1'b0;
      cnt_on_nxt = 1'b0;
      armed_nxt  = 1'b0;
    end

    res.rdata         = rdata;
    res.irq           = mode_nxt[MB_INT] | (mode_nxt[MB_TOF] & ~mode_nxt[MB_RST]);
    res.reset_request = (cause != CAUSE_NONE);
    res.reset_cause   = cause;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 5'd0;
      tc_r     <= TC_FLOOR;
      cnt_r    <= 32'd0;
      warn_r   <= 10'd0;
      win_r    <= WIN_OPEN;
      half_r   <= 1'b0;
      fed_r    <= 1'b0;
      cnt_on_r <= 1'b0;
      armed_r  <= 1'b0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      tc_r     <= tc_nxt;
      cnt_r    <= cnt_nxt;
      warn_r   <= warn_nxt;
      win_r    <= win_nxt;
      half_r   <= half_nxt;
      fed_r    <= fed_nxt;
      cnt_on_r <= cnt_on_nxt;
      armed_r  <= armed_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_on_r |-> mode_r[MB_EN])
    else $error("counter running with enable clear");

  a_armed_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> cnt_on_r)
    else $error("warning armed while counter stopped");

  a_tc_floor: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r >= TC_FLOOR)
    else $error("timeout constant below floor");

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.reset_request |=> mode_r == 5'd0 && !fed_r && !half_r)
    else $error("state not cleared after reset request");
`endif

endmodule

>>> hw/rtl/windowed_watchdog_unit.sv
// chan | dir | ports                                                  | handshake
// in   | in  | in_req_type, in_addr, in_wdata                         | in_valid / in_stall
// out  | out | out_rdata, out_irq, out_reset_request, out_reset_cause | out_valid / out_stall
//
// One transaction per cycle while out_stall is low, through the input and result registers.
// The state update and the result are one pass of logic behind the input register.
// rst_n is synchronous; it clears the watchdog state and both pipeline valids.
// in_stall rises only when the input register is full and the result register cannot drain.
module windowed_watchdog_unit import wwdt_pkg::*; #(
  parameter int ADDR_SPAN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [9:0]  in_addr,
  input  logic [31:0] in_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rdata,
  output logic        out_irq,
  output logic        out_reset_request,
  output logic [2:0]  out_reset_cause
);

  logic       s1_valid_r, s1_valid_nxt;
  wwdt_item_t s1_item_r;
  logic       out_valid_r, out_valid_nxt;
  wwdt_res_t  out_res_r;
  wwdt_res_t  res;
  logic       out_free;
  logic       fire;
  logic       in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  wwdt_core #(
    .ADDR_SPAN(ADDR_SPAN)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (s1_item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.req_type <= in_req_type;
      s1_item_r.addr     <= in_addr;
      s1_item_r.wdata    <= in_wdata;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rdata         = out_res_r.rdata;
  assign out_irq           = out_res_r.irq;
  assign out_reset_request = out_res_r.reset_request;
  assign out_reset_cause   = out_res_r.reset_cause;

`ifndef NO_ASSERTIONS
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !fire |=> s1_valid_r)
    else $error("held transaction dropped from input register");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_res_r))
    else $error("stalled result changed");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");
`endif

endmodule
